// ----- rtl/jsu_pkg.sv -----
// ============================================================================
// jsu_pkg
// Shared types, character codes and the UTF-8 encoder for the JSON string
// unescaper.
// ============================================================================
package jsu_pkg;

    // Width of the decoded length counter. The reported length saturates at
    // the counter maximum and again at the 16-bit port maximum.
    localparam int LENGTH_BITS = 16;

    // Depth of the command queue between the parser and the byte emitter.
    // It must be a power of two so the pointers wrap on their own.
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DIGIT_0   = 8'h30;
    localparam logic [7:0] CH_DIGIT_9   = 8'h39;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;

    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_TAB = 8'h09;

    // Top six bits of high and low surrogates.
    localparam logic [5:0] SUR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SUR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

    typedef enum logic [3:0] {
        ERR_NONE         = 4'd0,
        ERR_NO_QUOTE     = 4'd1,
        ERR_CONTROL      = 4'd2,
        ERR_BAD_ESCAPE   = 4'd3,
        ERR_BAD_UNICODE  = 4'd4,
        ERR_MISSING_PAIR = 4'd5,
        ERR_BAD_LOW      = 4'd6,
        ERR_UNTERM_ESC   = 4'd7,
        ERR_UNTERM_STR   = 4'd8
    } err_code_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_STR,
        FS_ESC,
        FS_HEX,
        FS_SUR_BS,
        FS_SUR_U,
        FS_HEX2
    } fstate_t;

    typedef enum logic [1:0] {
        CMD_BYTES,
        CMD_DONE,
        CMD_ERROR
    } cmd_kind_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;  // bytes[0] goes out first
        logic [1:0]      nm1;    // number of bytes minus one
    } utf8_t;

    typedef struct packed {
        cmd_kind_t kind;
        utf8_t     data;
        err_code_t err;
        logic      esc;
    } cmd_t;

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r.bytes = '0;
        if (cp < 21'h80) begin
            r.nm1      = 2'd0;
            r.bytes[0] = cp[7:0];
        end
        else if (cp < 21'h800) begin
            r.nm1      = 2'd1;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000) begin
            r.nm1      = 2'd2;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end
        else begin
            r.nm1      = 2'd3;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

// ----- rtl/json_string_unescape_utf8.sv -----
// ============================================================================
// json_string_unescape_utf8
// Streaming JSON string unescaper with UTF-8 output for unicode escapes.
//
// Channel   Handshake      Payload
// input     push / full    in_byte, end_of_input
// result    pop / empty    out_byte, byte_valid, string_done, error_code,
//                          decoded_length, had_escapes, last
//
// One input byte is taken per cycle while the command queue has room. A
// result item passes through the command queue and an output register.
// A completed unicode escape yields up to four items, sent one per cycle
// by the emitter while results are popped, so the emitter sets the result
// rate at one item per cycle. Stalls on the result side fill the four-entry
// command queue before full rises. Reset leaves the block idle, awaiting
// an opening quote, with the queue and the output register empty.
// ============================================================================
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        string_done,
    output logic [3:0]  error_code,
    output logic [15:0] decoded_length,
    output logic        had_escapes,
    output logic        last
);

    logic accept;
    logic cmd_push;
    cmd_t cmd;
    cmd_t head;
    logic head_empty;
    logic head_pop;

    assign accept = push && !full;

    jsu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .cmd_push     (cmd_push),
        .cmd          (cmd)
    );

    jsu_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd),
        .full    (full),
        .rd_en   (head_pop),
        .rd_data (head),
        .empty   (head_empty)
    );

    jsu_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .head_empty     (head_empty),
        .head_pop       (head_pop),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .string_done    (string_done),
        .error_code     (error_code),
        .decoded_length (decoded_length),
        .had_escapes    (had_escapes),
        .last           (last)
    );

endmodule

// ----- rtl/jsu_front.sv -----
// ============================================================================
// jsu_front
// Parser: accepts raw string bytes, tracks escape and surrogate state, and
// turns each byte into at most one command for the byte emitter.
// ============================================================================
module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output logic       cmd_push,
    output cmd_t       cmd
);

    fstate_t     state_reg, state_next;
    logic [15:0] acc_reg, acc_next;
    logic [9:0]  hs_reg, hs_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        esc_reg, esc_next;

    logic [4:0]  hex;
    logic [15:0] acc_shift;
    logic [20:0] pair_cp;

    function automatic logic [4:0] hexval(input logic [7:0] c);
        logic [4:0] r;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            r = {1'b1, 4'(c - CH_DIGIT_0)};
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            r = {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            r = {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
        end
        else begin
            r = 5'd0;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            acc_reg   <= '0;
            hs_reg    <= '0;
            cnt_reg   <= '0;
            esc_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            hs_reg    <= hs_next;
            cnt_reg   <= cnt_next;
            esc_reg   <= esc_next;
        end
    end

    always_comb
    begin
        hex       = hexval(in_byte);
        acc_shift = {acc_reg[11:0], hex[3:0]};
        pair_cp   = SUPPLEMENTARY_BASE + {1'b0, hs_reg, acc_shift[9:0]};

        state_next = state_reg;
        acc_next   = acc_reg;
        hs_next    = hs_reg;
        cnt_next   = cnt_reg;
        esc_next   = esc_reg;

        cmd_push       = 1'b0;
        cmd.kind       = CMD_BYTES;
        cmd.data.bytes = '0;
        cmd.data.nm1   = 2'd0;
        cmd.err        = ERR_NONE;
        cmd.esc        = esc_reg;

        if (accept)
        begin
            case (state_reg)
                FS_IDLE:
                begin
                    if (end_of_input || in_byte != CH_QUOTE)
                    begin
                        cmd_push = 1'b1;
                        cmd.kind = CMD_ERROR;
                        cmd.err  = ERR_NO_QUOTE;
                    end
                    else
                    begin
                        state_next = FS_STR;
                    end
                end
                FS_STR:
                begin
                    if (end_of_input)
                    begin
                        cmd_push = 1'b1;
                        cmd.kind = CMD_ERROR;
                        cmd.err  = ERR_UNTERM_STR;
                    end
                    else if (in_byte == CH_QUOTE)
                    begin
                        cmd_push = 1'b1;
                        cmd.kind = CMD_DONE;
                    end
                    else if (in_byte == CH_BACKSLASH)
                    begin
                        esc_next   = 1'b1;
                        state_next = FS_ESC;
                    end
                    else if (in_byte < CH_SPACE)
                    begin
                        cmd_push = 1'b1;
                        cmd.kind = CMD_ERROR;
                        cmd.err  = ERR_CONTROL;
                    end
                    else
                    begin
                        cmd_push          = 1'b1;
                        cmd.data.bytes[0] = in_byte;
                    end
                end
                FS_ESC:
                begin
                    if (end_of_input)
                    begin
                        cmd_push = 1'b1;
                        cmd.kind = CMD_ERROR;
                        cmd.err  = ERR_UNTERM_ESC;
                    end
                    else
                    begin
                        state_next = FS_STR;
                        cmd_push   = 1'b1;
                        case (in_byte)
                            CH_QUOTE, CH_BACKSLASH, CH_SLASH: cmd.data.bytes[0] = in_byte;
                            CH_B: cmd.data.bytes[0] = BYTE_BS;
                            CH_F: cmd.data.bytes[0] = BYTE_FF;
                            CH_N: cmd.data.bytes[0] = BYTE_LF;
                            CH_R: cmd.data.bytes[0] = BYTE_CR;
                            CH_T: cmd.data.bytes[0] = BYTE_TAB;
                            CH_U:
                            begin
                                cmd_push   = 1'b0;
                                state_next = FS_HEX;
                                acc_next   = '0;
                                cnt_next   = '0;
                            end
                            default:
                            begin
                                cmd.kind = CMD_ERROR;
                                cmd.err  = ERR_BAD_ESCAPE;
                            end
                        endcase
                    end
                end
                FS_HEX, FS_HEX2:
                begin
                    if (end_of_input || !hex[4])
                    begin
                        cmd_push = 1'b1;
                        cmd.kind = CMD_ERROR;
                        cmd.err  = ERR_BAD_UNICODE;
                    end
                    else if (cnt_reg != 2'd3)
                    begin
                        acc_next = acc_shift;
                        cnt_next = cnt_reg + 2'd1;
                    end
                    else
                    begin
                        acc_next = '0;
                        cnt_next = '0;
                        if (state_reg == FS_HEX)
                        begin
                            if (acc_shift[15:10] == SUR_HIGH_TAG)
                            begin
                                hs_next    = acc_shift[9:0];
                                state_next = FS_SUR_BS;
                            end
                            else
                            begin
                                state_next = FS_STR;
                                cmd_push   = 1'b1;
                                cmd.data   = utf8_encode({5'd0, acc_shift});
                            end
                        end
                        else if (acc_shift[15:10] != SUR_LOW_TAG)
                        begin
                            cmd_push = 1'b1;
                            cmd.kind = CMD_ERROR;
                            cmd.err  = ERR_BAD_LOW;
                        end
                        else
                        begin
                            hs_next    = '0;
                            state_next = FS_STR;
                            cmd_push   = 1'b1;
                            cmd.data   = utf8_encode(pair_cp);
                        end
                    end
                end
                FS_SUR_BS:
                begin
                    if (end_of_input || in_byte != CH_BACKSLASH)
                    begin
                        cmd_push = 1'b1;
                        cmd.kind = CMD_ERROR;
                        cmd.err  = ERR_MISSING_PAIR;
                    end
                    else
                    begin
                        state_next = FS_SUR_U;
                    end
                end
                FS_SUR_U:
                begin
                    if (end_of_input || in_byte != CH_U)
                    begin
                        cmd_push = 1'b1;
                        cmd.kind = CMD_ERROR;
                        cmd.err  = ERR_MISSING_PAIR;
                    end
                    else
                    begin
                        state_next = FS_HEX2;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end
                end
                default:
                begin
                    state_next = FS_IDLE;
                end
            endcase

            // Closing quotes and errors leave the parser idle with all state cleared.
            if (cmd_push && cmd.kind != CMD_BYTES)
            begin
                state_next = FS_IDLE;
                acc_next   = '0;
                hs_next    = '0;
                cnt_next   = '0;
                esc_next   = 1'b0;
            end
        end
    end

endmodule

// ----- rtl/jsu_cmd_fifo.sv -----
// ============================================================================
// jsu_cmd_fifo
// Short command queue between the parser and the byte emitter.
// ============================================================================
module jsu_cmd_fifo
    import jsu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic empty
);

    cmd_t                     mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_PTR_BITS:0]   count_reg;

    assign full    = (count_reg == (FIFO_PTR_BITS + 1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/jsu_back.sv -----
// ============================================================================
// jsu_back
// Byte emitter: expands queued commands into result items, one per cycle
// unless stalled, keeps the decoded length count, holds the result register.
// ============================================================================
module jsu_back
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head,
    input  logic        head_empty,
    output logic        head_pop,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        string_done,
    output logic [3:0]  error_code,
    output logic [15:0] decoded_length,
    output logic        had_escapes,
    output logic        last
);

    logic                   out_valid_reg, out_valid_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [1:0]             idx_reg, idx_next;

    logic [7:0]  byte_reg, byte_next;
    logic        bv_reg, bv_next;
    logic        done_reg, done_next;
    logic [3:0]  err_reg, err_next;
    logic [15:0] olen_reg, olen_next;
    logic        esc_reg, esc_next;
    logic        last_reg, last_next;

    logic                   advance;
    logic                   item_last;
    logic [LENGTH_BITS-1:0] len_inc;
    logic [LENGTH_BITS-1:0] item_len;
    logic [31:0]            item_len_wide;

    always_comb
    begin
        advance   = !head_empty && (!out_valid_reg || pop);
        item_last = (head.kind != CMD_BYTES) || (idx_reg == head.data.nm1);
        len_inc   = (len_reg != '1) ? len_reg + 1'b1 : len_reg;
        head_pop  = advance && item_last;

        out_valid_next = out_valid_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        item_len       = len_reg;

        byte_next = byte_reg;
        bv_next   = bv_reg;
        done_next = done_reg;
        err_next  = err_reg;
        esc_next  = esc_reg;
        last_next = last_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            idx_next       = item_last ? 2'd0 : idx_reg + 2'd1;
            esc_next       = head.esc;
            last_next      = item_last;
            case (head.kind)
                CMD_BYTES:
                begin
                    byte_next = head.data.bytes[idx_reg];
                    bv_next   = 1'b1;
                    done_next = 1'b0;
                    err_next  = ERR_NONE;
                    item_len  = len_inc;
                    len_next  = len_inc;
                end
                CMD_DONE:
                begin
                    byte_next = 8'd0;
                    bv_next   = 1'b0;
                    done_next = 1'b1;
                    err_next  = ERR_NONE;
                    len_next  = '0;
                end
                default:
                begin
                    byte_next = 8'd0;
                    bv_next   = 1'b0;
                    done_next = 1'b0;
                    err_next  = head.err;
                    len_next  = '0;
                end
            endcase
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        item_len_wide = 32'(item_len);
        olen_next     = (item_len_wide > 32'h0000_FFFF) ? 16'hFFFF : item_len_wide[15:0];
        if (!advance)
        begin
            olen_next = olen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        bv_reg   <= bv_next;
        done_reg <= done_next;
        err_reg  <= err_next;
        olen_reg <= olen_next;
        esc_reg  <= esc_next;
        last_reg <= last_next;
    end

    assign empty          = !out_valid_reg;
    assign out_byte       = byte_reg;
    assign byte_valid     = bv_reg;
    assign string_done    = done_reg;
    assign error_code     = err_reg;
    assign decoded_length = olen_reg;
    assign had_escapes    = esc_reg;
    assign last           = last_reg;

endmodule

// ----- sim/tb.sv -----
// ============================================================================
// tb
// Self-checking testbench for the streaming JSON string unescaper. A typed
// table of directed bytes runs first, then randomly built strings, mostly
// well formed with random content and some with injected faults. Each
// accepted byte runs through a decoder model in the testbench, and every
// result item is checked field by field against the oldest expected item.
// Both sides stall at random, except in the last random phase.
// ============================================================================
module tb;
    import jsu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam longint unsigned LEN_MAX = (64'd1 << LENGTH_BITS) - 1;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        string_done;
        logic [3:0]  error_code;
        logic [15:0] decoded_length;
        logic        had_escapes;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [7:0] b;
        logic       eoi;
    } raw_t;

    typedef struct packed {
        logic [7:0] b;
        logic       eoi;
        logic       typed;
        result_t    want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  in_byte;
    logic        end_of_input;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        string_done;
    logic [3:0]  error_code;
    logic [15:0] decoded_length;
    logic        had_escapes;
    logic        last;

    // Typed expectation that travels with the item currently offered.
    logic        typed_on;
    result_t     typed_exp;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_cnt = 0;
    int idle_cycles  = 0;

    // Decoder model state.
    fstate_t         dec_mode;
    logic [15:0]     code_acc;
    logic [15:0]     high_half;
    logic [1:0]      digit_cnt;
    longint unsigned out_len;
    logic            esc_flag;

    result_t   step_items[$];
    result_t   decoded_q[$];
    raw_t      pend_q[$];
    stim_row_t dir_rows[$];

    logic [7:0] esc_letters [8] = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B,
                                    CH_F, CH_N, CH_R, CH_T};

    json_string_unescape_utf8 u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .in_byte        (in_byte),
        .end_of_input   (end_of_input),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .string_done    (string_done),
        .error_code     (error_code),
        .decoded_length (decoded_length),
        .had_escapes    (had_escapes),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
            return int'(c - CH_DIGIT_0);
        if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            return int'(c - CH_LOWER_A) + 10;
        if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            return int'(c - CH_UPPER_A) + 10;
        return -1;
    endfunction

    function automatic void clear_decoder();
        dec_mode  = FS_IDLE;
        code_acc  = '0;
        high_half = '0;
        digit_cnt = '0;
        out_len   = 0;
        esc_flag  = 1'b0;
    endfunction

    function automatic void stage_item(input logic [7:0] ob, input logic bv,
                                       input logic done, input logic [3:0] err);
        result_t r;
        r.out_byte       = ob;
        r.byte_valid     = bv;
        r.string_done    = done;
        r.error_code     = err;
        r.decoded_length = (out_len > 64'hFFFF) ? 16'hFFFF : out_len[15:0];
        r.had_escapes    = esc_flag;
        r.last           = 1'b0;
        step_items.push_back(r);
    endfunction

    function automatic void emit_decoded(input logic [7:0] b);
        if (out_len < LEN_MAX)
            out_len++;
        stage_item(b, 1'b1, 1'b0, ERR_NONE);
    endfunction

    function automatic void fail_string(input logic [3:0] err);
        stage_item(8'h00, 1'b0, 1'b0, err);
        clear_decoder();
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            emit_decoded(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            emit_decoded(8'hC0 | 8'(cp >> 6));
            emit_decoded(8'h80 | 8'(cp & 21'h3F));
        end
        else if (cp < 21'h10000)
        begin
            emit_decoded(8'hE0 | 8'(cp >> 12));
            emit_decoded(8'h80 | 8'((cp >> 6) & 21'h3F));
            emit_decoded(8'h80 | 8'(cp & 21'h3F));
        end
        else
        begin
            emit_decoded(8'hF0 | 8'((cp >> 18) & 21'h07));
            emit_decoded(8'h80 | 8'((cp >> 12) & 21'h3F));
            emit_decoded(8'h80 | 8'((cp >> 6) & 21'h3F));
            emit_decoded(8'h80 | 8'(cp & 21'h3F));
        end
    endfunction

    // Advances the model by one raw byte and leaves its result items in
    // step_items, the final one marked.
    function automatic void unescape_step(input logic [7:0] c, input logic eoi);
        int d;
        logic [20:0] cp;
        step_items.delete();
        case (dec_mode)
            FS_IDLE:
            begin
                if (eoi || c != CH_QUOTE)
                    fail_string(ERR_NO_QUOTE);
                else
                begin
                    clear_decoder();
                    dec_mode = FS_STR;
                end
            end
            FS_STR:
            begin
                if (eoi)
                    fail_string(ERR_UNTERM_STR);
                else if (c == CH_QUOTE)
                begin
                    stage_item(8'h00, 1'b0, 1'b1, ERR_NONE);
                    clear_decoder();
                end
                else if (c == CH_BACKSLASH)
                begin
                    esc_flag = 1'b1;
                    dec_mode = FS_ESC;
                end
                else if (c < CH_SPACE)
                    fail_string(ERR_CONTROL);
                else
                    emit_decoded(c);
            end
            FS_ESC:
            begin
                if (eoi)
                    fail_string(ERR_UNTERM_ESC);
                else
                begin
                    dec_mode = FS_STR;
                    case (c)
                        CH_QUOTE, CH_BACKSLASH, CH_SLASH: emit_decoded(c);
                        CH_B: emit_decoded(BYTE_BS);
                        CH_F: emit_decoded(BYTE_FF);
                        CH_N: emit_decoded(BYTE_LF);
                        CH_R: emit_decoded(BYTE_CR);
                        CH_T: emit_decoded(BYTE_TAB);
                        CH_U:
                        begin
                            dec_mode  = FS_HEX;
                            code_acc  = '0;
                            digit_cnt = '0;
                        end
                        default: fail_string(ERR_BAD_ESCAPE);
                    endcase
                end
            end
            FS_HEX, FS_HEX2:
            begin
                d = hex_value(c);
                if (eoi || d < 0)
                    fail_string(ERR_BAD_UNICODE);
                else
                begin
                    code_acc = {code_acc[11:0], 4'(d)};
                    if (digit_cnt != 2'd3)
                        digit_cnt++;
                    else
                    begin
                        digit_cnt = '0;
                        cp        = 21'(code_acc);
                        code_acc  = '0;
                        if (dec_mode == FS_HEX)
                        begin
                            if (cp >= 21'hD800 && cp <= 21'hDBFF)
                            begin
                                high_half = cp[15:0];
                                dec_mode  = FS_SUR_BS;
                            end
                            else
                            begin
                                dec_mode = FS_STR;
                                emit_code_point(cp);
                            end
                        end
                        else if (cp < 21'hDC00 || cp > 21'hDFFF)
                            fail_string(ERR_BAD_LOW);
                        else
                        begin
                            cp = 21'h10000 + ((21'(high_half) - 21'hD800) << 10)
                                 + (cp - 21'hDC00);
                            high_half = '0;
                            dec_mode  = FS_STR;
                            emit_code_point(cp);
                        end
                    end
                end
            end
            FS_SUR_BS:
            begin
                if (eoi || c != CH_BACKSLASH)
                    fail_string(ERR_MISSING_PAIR);
                else
                    dec_mode = FS_SUR_U;
            end
            FS_SUR_U:
            begin
                if (eoi || c != CH_U)
                    fail_string(ERR_MISSING_PAIR);
                else
                begin
                    dec_mode  = FS_HEX2;
                    code_acc  = '0;
                    digit_cnt = '0;
                end
            end
            default: fail_string(ERR_NO_QUOTE);
        endcase
        if (step_items.size() > 0)
            step_items[step_items.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        string   bad;
        logic    took;
        if (rst_n)
        begin
            took = 1'b0;
            if (push && !full)
            begin
                took = 1'b1;
                unescape_step(in_byte, end_of_input);
                if (typed_on)
                    decoded_q.push_back(typed_exp);
                else
                    foreach (step_items[i])
                        decoded_q.push_back(step_items[i]);
            end
            if (pop && !empty)
            begin
                took = 1'b1;
                got = {out_byte, byte_valid, string_done, error_code,
                       decoded_length, had_escapes, last};
                if (decoded_q.size() == 0)
                    report_mismatch($sformatf("result item %h with nothing expected", got));
                else
                begin
                    want = decoded_q.pop_front();
                    bad  = "";
                    if (got.out_byte !== want.out_byte)
                        bad = {bad, " out_byte"};
                    if (got.byte_valid !== want.byte_valid)
                        bad = {bad, " byte_valid"};
                    if (got.string_done !== want.string_done)
                        bad = {bad, " string_done"};
                    if (got.error_code !== want.error_code)
                        bad = {bad, " error_code"};
                    if (got.decoded_length !== want.decoded_length)
                        bad = {bad, " decoded_length"};
                    if (got.had_escapes !== want.had_escapes)
                        bad = {bad, " had_escapes"};
                    if (got.last !== want.last)
                        bad = {bad, " last"};
                    if (bad != "")
                        report_mismatch($sformatf("bad%s: got %h, want %h", bad, got, want));
                end
            end
            idle_cycles = took ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    // Entered just after a falling edge; returns at the falling edge that
    // follows acceptance, with push still high.
    task automatic send_item(input logic [7:0] b, input logic e,
                             input logic t_on, input result_t t_exp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push         <= 1'b1;
        in_byte      <= b;
        end_of_input <= e;
        typed_on     <= t_on;
        typed_exp    <= t_exp;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    function automatic void put_raw(input logic [7:0] b, input logic e);
        pend_q.push_back('{b, e});
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return CH_DIGIT_0 + 8'(n);
        if ($urandom_range(1))
            return CH_LOWER_A + 8'(n - 4'd10);
        return CH_UPPER_A + 8'(n - 4'd10);
    endfunction

    function automatic void put_unicode(input logic [15:0] v);
        put_raw(CH_BACKSLASH, 1'b0);
        put_raw(CH_U, 1'b0);
        for (int i = 3; i >= 0; i--)
            put_raw(hex_char(v[4*i +: 4]), 1'b0);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(8'h20, 8'hFF));
        while (b == CH_QUOTE || b == CH_BACKSLASH);
        return b;
    endfunction

    // Builds one string in pend_q: usually well formed with random content,
    // sometimes cut short by a fault, now and then garbage before the quote.
    function automatic void gen_string();
        int nseg;
        int fault;
        logic [7:0] b;
        logic [15:0] v;
        if ($urandom_range(19) == 0)
        begin
            if ($urandom_range(1))
                put_raw(8'($urandom), 1'b1);
            else
            begin
                do
                    b = 8'($urandom);
                while (b == CH_QUOTE);
                put_raw(b, 1'b0);
            end
            return;
        end
        put_raw(CH_QUOTE, 1'b0);
        nseg = $urandom_range(0, 8);
        for (int s = 0; s < nseg; s++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: put_raw(plain_char(), 1'b0);
                4, 5:
                begin
                    put_raw(CH_BACKSLASH, 1'b0);
                    put_raw(esc_letters[$urandom_range(7)], 1'b0);
                end
                6, 7:
                begin
                    // Spread over one, two and three byte encodings and
                    // lone low surrogates.
                    do
                    begin
                        case ($urandom_range(3))
                            0: v = 16'($urandom_range(16'h0000, 16'h007F));
                            1: v = 16'($urandom_range(16'h0080, 16'h07FF));
                            2: v = 16'($urandom_range(16'h0800, 16'hFFFF));
                            default: v = 16'($urandom_range(16'hDC00, 16'hDFFF));
                        endcase
                    end
                    while (v >= 16'hD800 && v <= 16'hDBFF);
                    put_unicode(v);
                end
                8:
                begin
                    put_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
                    put_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
                end
                default: put_raw(8'($urandom), 1'b0);
            endcase
        end
        if ($urandom_range(4) != 0)
        begin
            put_raw(CH_QUOTE, 1'b0);
            return;
        end
        fault = $urandom_range(ERR_CONTROL, ERR_UNTERM_STR);
        case (fault)
            ERR_CONTROL: put_raw(8'($urandom_range(8'h00, 8'h1F)), 1'b0);
            ERR_BAD_ESCAPE:
            begin
                put_raw(CH_BACKSLASH, 1'b0);
                do
                    b = 8'($urandom);
                while (b inside {esc_letters, CH_U});
                put_raw(b, 1'b0);
            end
            ERR_BAD_UNICODE:
            begin
                put_raw(CH_BACKSLASH, 1'b0);
                put_raw(CH_U, 1'b0);
                repeat ($urandom_range(0, 3))
                    put_raw(hex_char(4'($urandom)), 1'b0);
                if ($urandom_range(1))
                    put_raw(8'($urandom), 1'b1);
                else
                begin
                    do
                        b = 8'($urandom);
                    while (hex_value(b) >= 0);
                    put_raw(b, 1'b0);
                end
            end
            ERR_MISSING_PAIR:
            begin
                put_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
                case ($urandom_range(3))
                    0: put_raw(8'($urandom), 1'b1);
                    1:
                    begin
                        do
                            b = 8'($urandom);
                        while (b == CH_BACKSLASH);
                        put_raw(b, 1'b0);
                    end
                    2:
                    begin
                        put_raw(CH_BACKSLASH, 1'b0);
                        put_raw(8'($urandom), 1'b1);
                    end
                    default:
                    begin
                        put_raw(CH_BACKSLASH, 1'b0);
                        do
                            b = 8'($urandom);
                        while (b == CH_U);
                        put_raw(b, 1'b0);
                    end
                endcase
            end
            ERR_BAD_LOW:
            begin
                put_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
                do
                    v = 16'($urandom);
                while (v >= 16'hDC00 && v <= 16'hDFFF);
                put_unicode(v);
            end
            ERR_UNTERM_ESC:
            begin
                put_raw(CH_BACKSLASH, 1'b0);
                put_raw(8'($urandom), 1'b1);
            end
            default: put_raw(8'($urandom), 1'b1);
        endcase
    endfunction

    task automatic run_random(input int n_items);
        int sent;
        raw_t r;
        sent = 0;
        while (sent < n_items)
        begin
            gen_string();
            while (pend_q.size() > 0)
            begin
                r = pend_q.pop_front();
                send_item(r.b, r.eoi, 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        in_byte       = 8'h00;
        end_of_input  = 1'b0;
        typed_on      = 1'b0;
        typed_exp     = '0;
        send_idle_pct = 27;
        recv_idle_pct = 50;
        clear_decoder();

        // Directed rows: byte, end of input, typed, typed expectation.
        dir_rows.push_back('{8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_NO_QUOTE,
                                                  16'd0, 1'b0, 1'b1}});
        dir_rows.push_back('{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_NO_QUOTE,
                                                  16'd0, 1'b0, 1'b1}});
        dir_rows.push_back('{CH_QUOTE, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_CONTROL,
                                                  16'd0, 1'b0, 1'b1}});
        dir_rows.push_back('{CH_QUOTE, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, ERR_NONE,
                                                  16'd1, 1'b0, 1'b1}});
        // The smallest code point, U+0000.
        dir_rows.push_back('{CH_BACKSLASH, 1'b0, 1'b0, '0});
        dir_rows.push_back('{CH_U, 1'b0, 1'b0, '0});
        repeat (3)
            dir_rows.push_back('{CH_DIGIT_0, 1'b0, 1'b0, '0});
        dir_rows.push_back('{CH_DIGIT_0, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, ERR_NONE,
                                                       16'd2, 1'b1, 1'b1}});
        // The largest code point, U+10FFFF, from the pair DBFF DFFF.
        dir_rows.push_back('{CH_BACKSLASH, 1'b0, 1'b0, '0});
        dir_rows.push_back('{CH_U, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h64, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h62, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h66, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h66, 1'b0, 1'b0, '0});
        dir_rows.push_back('{CH_BACKSLASH, 1'b0, 1'b0, '0});
        dir_rows.push_back('{CH_U, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h44, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h46, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h46, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h46, 1'b0, 1'b0, '0});
        dir_rows.push_back('{CH_BACKSLASH, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h71, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_BAD_ESCAPE,
                                                  16'd6, 1'b1, 1'b1}});
        dir_rows.push_back('{CH_QUOTE, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_UNTERM_STR,
                                                  16'd0, 1'b0, 1'b1}});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].b, dir_rows[i].eoi, dir_rows[i].typed,
                      dir_rows[i].want);
        run_random(ITEMS_PER_PHASE);

        send_idle_pct = 50;
        recv_idle_pct = 27;
        run_random(ITEMS_PER_PHASE);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(ITEMS_PER_PHASE);

        push <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
